// ===== hdl/mepl_pkg.sv =====
// mepl_pkg: shared types, codes and sizes for the midi event parser and log
// used by mepl_ctrl, mepl_dp and midi_event_parser_log_top; depends on nothing

package mepl_pkg;

    localparam int EVENT_DEPTH = 16;
    localparam int SLOT_W      = $clog2(EVENT_DEPTH);
    localparam int CNT_W       = $clog2(EVENT_DEPTH + 1);
    localparam int CMP_W       = (CNT_W > 4) ? CNT_W : 4;

    localparam logic [7:0] CLOCK_DIV_RESET = 8'd6;
    localparam logic [7:0] CLOCK_BYTE      = 8'hF8;
    localparam logic [3:0] SYSTEM_NIBBLE   = 4'hF;

    localparam logic [3:0] TYPE_NOTE_OFF   = 4'h8;
    localparam logic [3:0] TYPE_NOTE_ON    = 4'h9;
    localparam logic [3:0] TYPE_CC         = 4'hB;
    localparam logic [3:0] TYPE_PROG       = 4'hC;
    localparam logic [3:0] TYPE_CHAN_PRESS = 4'hD;
    localparam logic [3:0] TYPE_BEND       = 4'hE;

    localparam logic [1:0] REQ_MIDI = 2'd0;
    localparam logic [1:0] REQ_TICK = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    localparam logic [2:0] ACT_NONE       = 3'd0;
    localparam logic [2:0] ACT_APPENDED   = 3'd1;
    localparam logic [2:0] ACT_OVERWRITE  = 3'd2;
    localparam logic [2:0] ACT_MARKED     = 3'd3;
    localparam logic [2:0] ACT_CLOCK      = 3'd4;
    localparam logic [2:0] ACT_READ_DATA  = 3'd5;
    localparam logic [2:0] ACT_READ_EMPTY = 3'd6;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
        logic [3:0] age_index;
    } req_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [3:0]  slot;
        logic [4:0]  marked_count;
        logic [3:0]  entry_type;
        logic [3:0]  entry_channel;
        logic [6:0]  entry_val1;
        logic [6:0]  entry_val2;
        logic [31:0] entry_time;
        logic [31:0] entry_age;
        logic [4:0]  event_count;
    } res_t;

    typedef struct packed {
        logic [31:0] etime;
        logic [3:0]  etype;
        logic [3:0]  chan;
        logic [6:0]  v1;
        logic [6:0]  v2;
    } log_entry_t;

    typedef enum logic [2:0] {
        JOB_NONE   = 3'd0,
        JOB_APPEND = 3'd1,
        JOB_SCAN   = 3'd2,
        JOB_NEWEST = 3'd3,
        JOB_READ   = 3'd4
    } job_t;

    typedef struct packed {
        logic accept;
        logic scan_step;
        logic mark_res;
        logic newest_rd;
        logic overwrite;
        logic append;
        logic read_rd;
        logic read_res;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        job_t job;
        logic scan_done;
        logic scan_marked;
        logic newest_match;
        logic out_free;
    } sts_t;

endpackage

// ===== hdl/midi_event_parser_log_top.sv =====
// midi_event_parser_log_top: top level of the midi event parser and log
// instantiates mepl_ctrl and mepl_dp; uses mepl_pkg for payload and control types
//
// The block takes one request item at a time: a MIDI byte, a time tick or a read of the
// event log, and gives exactly one result item for each. Bytes that finish no message,
// ticks, clock bytes and empty reads go straight to the result; a log read first reads
// the entry. A finished message is appended at once when the log is empty; otherwise the
// newest entry is read and checked, then overwritten or a new entry appended, except a
// note-off, which walks the valid log entries newest first, one read of the log memory
// per cycle, then marks the matching note-on entries or appends when none match. A finished
// result sits in an output register, so one more request can be taken and worked while
// it waits; a stalled output holds the next result back. clock_divide is to be written
// through cfg_write/cfg_data only while the block is idle; the block itself does not
// enforce this. There is no clearing pass after reset.

module midi_event_parser_log_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_write,
    input  logic [7:0]     cfg_data,
    input  logic           req_valid,
    output logic           req_stall,
    input  mepl_pkg::req_t req,
    output logic           res_valid,
    input  logic           res_stall,
    output mepl_pkg::res_t res
);

    mepl_pkg::cmd_t cmd;
    mepl_pkg::sts_t sts;

    mepl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    mepl_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .req       (req),
        .res_stall (res_stall),
        .res_valid (res_valid),
        .res       (res),
        .cmd       (cmd),
        .sts       (sts)
    );

    // an accepted item keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request taken while previous item still in work");

    // the output register is only loaded once its item is gone
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result register overwritten before it was taken");

    // a marked-off result always reports at least one marked entry
    a_marked_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.action == mepl_pkg::ACT_MARKED)) |-> (res.marked_count != 5'd0))
        else $error("notes marked off with zero count");

endmodule

// ===== hdl/mepl_ctrl.sv =====
// mepl_ctrl: sequencer for the midi event parser and log
// uses mepl_pkg for the command and status structs

module mepl_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  mepl_pkg::sts_t sts,
    output mepl_pkg::cmd_t cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_SCAN     = 8'b0000_0010,
        S_NEW_RD   = 8'b0000_0100,
        S_NEW_CHK  = 8'b0000_1000,
        S_APPEND   = 8'b0001_0000,
        S_READ_RD  = 8'b0010_0000,
        S_READ_OUT = 8'b0100_0000,
        S_POST     = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    unique case (sts.job)
                        mepl_pkg::JOB_APPEND: state_next = S_APPEND;
                        mepl_pkg::JOB_SCAN:   state_next = S_SCAN;
                        mepl_pkg::JOB_NEWEST: state_next = S_NEW_RD;
                        mepl_pkg::JOB_READ:   state_next = S_READ_RD;
                        default:              state_next = S_POST;
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done)
                begin
                    if (sts.scan_marked)
                    begin
                        cmd.mark_res = 1'b1;
                        state_next   = S_POST;
                    end
                    else
                    begin
                        state_next = S_APPEND;
                    end
                end
            end
            S_NEW_RD:
            begin
                cmd.newest_rd = 1'b1;
                state_next    = S_NEW_CHK;
            end
            S_NEW_CHK:
            begin
                if (sts.newest_match)
                begin
                    cmd.overwrite = 1'b1;
                    state_next    = S_POST;
                end
                else
                begin
                    state_next = S_APPEND;
                end
            end
            S_APPEND:
            begin
                cmd.append = 1'b1;
                state_next = S_POST;
            end
            S_READ_RD:
            begin
                cmd.read_rd = 1'b1;
                state_next  = S_READ_OUT;
            end
            S_READ_OUT:
            begin
                cmd.read_res = 1'b1;
                state_next   = S_POST;
            end
            S_POST:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/mepl_dp.sv =====
// mepl_dp: parser registers, event log memory, note-off scan and result registers
// uses mepl_pkg; driven by mepl_ctrl through cmd_t and reports through sts_t

module mepl_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [7:0]          cfg_data,
    input  mepl_pkg::req_t      req,
    input  logic                res_stall,
    output logic                res_valid,
    output mepl_pkg::res_t      res,
    input  mepl_pkg::cmd_t      cmd,
    output mepl_pkg::sts_t      sts
);

    localparam int SW = mepl_pkg::SLOT_W;
    localparam int CW = mepl_pkg::CNT_W;
    localparam logic [SW:0]   DEPTH_W    = (SW + 1)'(mepl_pkg::EVENT_DEPTH);
    localparam logic [SW-1:0] LAST_SLOT  = SW'(mepl_pkg::EVENT_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT  = CW'(mepl_pkg::EVENT_DEPTH);

    // event log, contents undefined until written
    mepl_pkg::log_entry_t mem [mepl_pkg::EVENT_DEPTH];
    mepl_pkg::log_entry_t rd_data_reg;

    logic                 mem_we;
    logic [SW-1:0]        mem_waddr;
    mepl_pkg::log_entry_t mem_wdata;
    logic                 mem_re;
    logic [SW-1:0]        mem_raddr;

    // control state
    logic [7:0]    clk_div_reg,    clk_div_next;
    logic [3:0]    pend_type_reg,  pend_type_next;
    logic [3:0]    pend_chan_reg,  pend_chan_next;
    logic [1:0]    bytes_need_reg, bytes_need_next;
    logic [6:0]    first_data_reg, first_data_next;
    logic [31:0]   tick_reg,       tick_next;
    logic [7:0]    clk_cnt_reg,    clk_cnt_next;
    logic [CW-1:0] valid_cnt_reg,  valid_cnt_next;
    logic [SW-1:0] newest_reg,     newest_next;
    logic [CW-1:0] scan_idx_reg,   scan_idx_next;
    logic          chk_valid_reg,  chk_valid_next;
    logic [CW-1:0] marked_reg,     marked_next;
    logic          out_valid_reg,  out_valid_next;

    // payload
    logic [3:0]     msg_type_reg,   msg_type_next;
    logic [3:0]     msg_chan_reg,   msg_chan_next;
    logic [6:0]     msg_v1_reg,     msg_v1_next;
    logic [6:0]     msg_v2_reg,     msg_v2_next;
    logic [SW-1:0]  rd_slot_reg,    rd_slot_next;
    logic [SW-1:0]  scan_slot_reg,  scan_slot_next;
    logic [SW-1:0]  chk_slot_reg,   chk_slot_next;
    logic [SW-1:0]  first_slot_reg, first_slot_next;
    logic [6:0]     first_v2_reg,   first_v2_next;
    mepl_pkg::res_t res_reg,        res_next;
    mepl_pkg::res_t out_reg,        out_next;

    // helpers
    logic [8:0]     clk_inc;
    logic [SW-1:0]  age_sl;
    logic [SW:0]    age_wrap;
    logic [SW-1:0]  age_slot;
    logic [SW:0]    newest_inc;
    logic [SW-1:0]  append_slot;
    logic [CW-1:0]  append_cnt;
    logic           scan_issue;
    logic           scan_hit;
    logic           is_one_byte;
    logic [2:0]     imm_action;
    mepl_pkg::job_t job;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_comb
    begin
        clk_inc     = {1'b0, clk_cnt_reg} + 9'd1;
        age_sl      = SW'(req.age_index);
        age_wrap    = {1'b0, newest_reg} + DEPTH_W - {1'b0, age_sl};
        age_slot    = (newest_reg >= age_sl) ? (newest_reg - age_sl) : age_wrap[SW-1:0];
        newest_inc  = {1'b0, newest_reg} + (SW + 1)'(1);
        append_slot = (newest_inc >= DEPTH_W) ? '0 : newest_inc[SW-1:0];
        append_cnt  = (valid_cnt_reg < DEPTH_CNT) ? (valid_cnt_reg + CW'(1)) : valid_cnt_reg;
        is_one_byte = (pend_type_reg == mepl_pkg::TYPE_PROG) ||
                      (pend_type_reg == mepl_pkg::TYPE_CHAN_PRESS);
        scan_issue  = (scan_idx_reg < valid_cnt_reg);
        scan_hit    = chk_valid_reg &&
                      (rd_data_reg.etype == mepl_pkg::TYPE_NOTE_ON) &&
                      (rd_data_reg.v1 == msg_v1_reg) &&
                      (rd_data_reg.chan == msg_chan_reg);
    end

    // classify the offered item and work out its immediate effects
    always_comb
    begin
        job             = mepl_pkg::JOB_NONE;
        imm_action      = mepl_pkg::ACT_NONE;
        clk_cnt_next    = clk_cnt_reg;
        pend_type_next  = pend_type_reg;
        pend_chan_next  = pend_chan_reg;
        bytes_need_next = bytes_need_reg;
        first_data_next = first_data_reg;
        tick_next       = tick_reg;
        msg_type_next   = msg_type_reg;
        msg_chan_next   = msg_chan_reg;
        msg_v1_next     = msg_v1_reg;
        msg_v2_next     = msg_v2_reg;
        rd_slot_next    = rd_slot_reg;
        unique case (req.req_type)
            mepl_pkg::REQ_MIDI:
            begin
                if (req.data_byte == mepl_pkg::CLOCK_BYTE)
                begin
                    if (clk_inc >= {1'b0, clk_div_reg})
                    begin
                        clk_cnt_next = '0;
                        imm_action   = mepl_pkg::ACT_CLOCK;
                    end
                    else
                    begin
                        clk_cnt_next = clk_inc[7:0];
                    end
                end
                else if (req.data_byte[7:4] == mepl_pkg::SYSTEM_NIBBLE)
                begin
                    // other system bytes leave an open message alone
                end
                else if (req.data_byte[7])
                begin
                    pend_type_next  = req.data_byte[7:4];
                    pend_chan_next  = req.data_byte[3:0];
                    first_data_next = '0;
                    bytes_need_next = ((req.data_byte[7:4] == mepl_pkg::TYPE_PROG) ||
                                       (req.data_byte[7:4] == mepl_pkg::TYPE_CHAN_PRESS))
                                      ? 2'd1 : 2'd2;
                end
                else if (bytes_need_reg == 2'd2)
                begin
                    first_data_next = req.data_byte[6:0];
                    bytes_need_next = 2'd1;
                end
                else if (bytes_need_reg == 2'd1)
                begin
                    bytes_need_next = 2'd0;
                    msg_type_next   = pend_type_reg;
                    msg_chan_next   = pend_chan_reg;
                    msg_v1_next     = is_one_byte ? req.data_byte[6:0] : first_data_reg;
                    msg_v2_next     = is_one_byte ? 7'd0 : req.data_byte[6:0];
                    if (valid_cnt_reg == '0)
                    begin
                        job = mepl_pkg::JOB_APPEND;
                    end
                    else if (pend_type_reg == mepl_pkg::TYPE_NOTE_OFF)
                    begin
                        job = mepl_pkg::JOB_SCAN;
                    end
                    else
                    begin
                        job = mepl_pkg::JOB_NEWEST;
                    end
                end
            end
            mepl_pkg::REQ_TICK:
            begin
                tick_next = tick_reg + 32'd1;
            end
            mepl_pkg::REQ_READ:
            begin
                if (mepl_pkg::CMP_W'(req.age_index) < mepl_pkg::CMP_W'(valid_cnt_reg))
                begin
                    job          = mepl_pkg::JOB_READ;
                    rd_slot_next = age_slot;
                end
                else
                begin
                    imm_action = mepl_pkg::ACT_READ_EMPTY;
                end
            end
            default:
            begin
                imm_action = mepl_pkg::ACT_NONE;
            end
        endcase
    end

    // sequenced work on the log
    always_comb
    begin
        valid_cnt_next  = valid_cnt_reg;
        newest_next     = newest_reg;
        scan_idx_next   = scan_idx_reg;
        scan_slot_next  = scan_slot_reg;
        chk_valid_next  = chk_valid_reg;
        chk_slot_next   = chk_slot_reg;
        marked_next     = marked_reg;
        first_slot_next = first_slot_reg;
        first_v2_next   = first_v2_reg;
        res_next        = res_reg;
        mem_we          = 1'b0;
        mem_waddr       = newest_reg;
        mem_wdata       = '{etime: tick_reg, etype: msg_type_reg, chan: msg_chan_reg,
                            v1: msg_v1_reg, v2: msg_v2_reg};
        mem_re          = 1'b0;
        mem_raddr       = newest_reg;

        if (cmd.accept)
        begin
            res_next             = '0;
            res_next.action      = imm_action;
            res_next.event_count = 5'(valid_cnt_reg);
            scan_idx_next        = '0;
            scan_slot_next       = newest_reg;
            chk_valid_next       = 1'b0;
            marked_next          = '0;
        end

        if (cmd.scan_step)
        begin
            // issue one read per cycle, check the entry read the cycle before
            chk_valid_next = scan_issue;
            chk_slot_next  = scan_slot_reg;
            if (scan_issue)
            begin
                mem_re         = 1'b1;
                mem_raddr      = scan_slot_reg;
                scan_idx_next  = scan_idx_reg + CW'(1);
                scan_slot_next = (scan_slot_reg == '0) ? LAST_SLOT : (scan_slot_reg - SW'(1));
            end
            if (scan_hit)
            begin
                mem_we          = 1'b1;
                mem_waddr       = chk_slot_reg;
                mem_wdata       = rd_data_reg;
                mem_wdata.etype = mepl_pkg::TYPE_NOTE_OFF;
                mem_wdata.etime = tick_reg;
                marked_next     = marked_reg + CW'(1);
                if (marked_reg == '0)
                begin
                    first_slot_next = chk_slot_reg;
                    first_v2_next   = rd_data_reg.v2;
                end
            end
        end

        if (cmd.mark_res)
        begin
            res_next               = '0;
            res_next.action        = mepl_pkg::ACT_MARKED;
            res_next.slot          = 4'(first_slot_reg);
            res_next.marked_count  = 5'(marked_reg);
            res_next.entry_type    = mepl_pkg::TYPE_NOTE_OFF;
            res_next.entry_channel = msg_chan_reg;
            res_next.entry_val1    = msg_v1_reg;
            res_next.entry_val2    = first_v2_reg;
            res_next.entry_time    = tick_reg;
            res_next.event_count   = 5'(valid_cnt_reg);
        end

        if (cmd.newest_rd)
        begin
            mem_re    = 1'b1;
            mem_raddr = newest_reg;
        end

        if (cmd.read_rd)
        begin
            mem_re    = 1'b1;
            mem_raddr = rd_slot_reg;
        end

        if (cmd.overwrite || cmd.append)
        begin
            mem_we                 = 1'b1;
            res_next               = '0;
            res_next.entry_type    = msg_type_reg;
            res_next.entry_channel = msg_chan_reg;
            res_next.entry_val1    = msg_v1_reg;
            res_next.entry_val2    = msg_v2_reg;
            res_next.entry_time    = tick_reg;
            if (cmd.append)
            begin
                mem_waddr            = append_slot;
                newest_next          = append_slot;
                valid_cnt_next       = append_cnt;
                res_next.action      = mepl_pkg::ACT_APPENDED;
                res_next.slot        = 4'(append_slot);
                res_next.event_count = 5'(append_cnt);
            end
            else
            begin
                res_next.action      = mepl_pkg::ACT_OVERWRITE;
                res_next.slot        = 4'(newest_reg);
                res_next.event_count = 5'(valid_cnt_reg);
            end
        end

        if (cmd.read_res)
        begin
            res_next.action        = mepl_pkg::ACT_READ_DATA;
            res_next.slot          = 4'(rd_slot_reg);
            res_next.marked_count  = '0;
            res_next.entry_type    = rd_data_reg.etype;
            res_next.entry_channel = rd_data_reg.chan;
            res_next.entry_val1    = rd_data_reg.v1;
            res_next.entry_val2    = rd_data_reg.v2;
            res_next.entry_time    = rd_data_reg.etime;
            res_next.entry_age     = tick_reg - rd_data_reg.etime;
            res_next.event_count   = 5'(valid_cnt_reg);
        end
    end

    always_comb
    begin
        clk_div_next   = cfg_write ? cfg_data : clk_div_reg;
        out_next       = cmd.out_load ? res_reg : out_reg;
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clk_div_reg    <= mepl_pkg::CLOCK_DIV_RESET;
            pend_type_reg  <= '0;
            pend_chan_reg  <= '0;
            bytes_need_reg <= '0;
            first_data_reg <= '0;
            tick_reg       <= '0;
            clk_cnt_reg    <= '0;
            valid_cnt_reg  <= '0;
            newest_reg     <= '0;
            scan_idx_reg   <= '0;
            chk_valid_reg  <= 1'b0;
            marked_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            clk_div_reg    <= clk_div_next;
            valid_cnt_reg  <= valid_cnt_next;
            newest_reg     <= newest_next;
            scan_idx_reg   <= scan_idx_next;
            chk_valid_reg  <= chk_valid_next;
            marked_reg     <= marked_next;
            out_valid_reg  <= out_valid_next;
            if (cmd.accept)
            begin
                pend_type_reg  <= pend_type_next;
                pend_chan_reg  <= pend_chan_next;
                bytes_need_reg <= bytes_need_next;
                first_data_reg <= first_data_next;
                tick_reg       <= tick_next;
                clk_cnt_reg    <= clk_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            msg_type_reg <= msg_type_next;
            msg_chan_reg <= msg_chan_next;
            msg_v1_reg   <= msg_v1_next;
            msg_v2_reg   <= msg_v2_next;
            rd_slot_reg  <= rd_slot_next;
        end
        scan_slot_reg  <= scan_slot_next;
        chk_slot_reg   <= chk_slot_next;
        first_slot_reg <= first_slot_next;
        first_v2_reg   <= first_v2_next;
        res_reg        <= res_next;
        out_reg        <= out_next;
    end

    assign res_valid        = out_valid_reg;
    assign res              = out_reg;
    assign sts.job          = job;
    assign sts.scan_done    = !scan_issue && !chk_valid_reg;
    assign sts.scan_marked  = (marked_reg != '0);
    assign sts.newest_match = (rd_data_reg.chan == msg_chan_reg) &&
                              (rd_data_reg.etype == msg_type_reg) &&
                              (((msg_type_reg == mepl_pkg::TYPE_CC) &&
                                (rd_data_reg.v1 == msg_v1_reg)) ||
                               (msg_type_reg == mepl_pkg::TYPE_BEND) ||
                               (msg_type_reg == mepl_pkg::TYPE_CHAN_PRESS));
    assign sts.out_free     = !out_valid_reg || !res_stall;

endmodule
